### hdl/nec_ir_pkg.sv
package nec_ir_pkg;

  localparam int PERIOD_WIDTH_DEF = 16;

  localparam int FRAME_BITS = 32;
  localparam int BITPOS_W   = 6;
  localparam int TICK_W     = 8;
  localparam int CODE_W     = 16;
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 3;

  // bit position value that marks a finished frame waiting for a restart
  localparam logic [BITPOS_W-1:0] BITPOS_WAIT = '1;
  localparam logic [BITPOS_W-1:0] BITPOS_LAST = BITPOS_W'(FRAME_BITS - 1);

  localparam logic [7:0] BYTE_ONES = 8'hff;

  // request codes
  localparam logic [1:0] REQ_PERIOD  = 2'd0;
  localparam logic [1:0] REQ_TIMEOUT = 2'd1;
  localparam logic [1:0] REQ_ACK     = 2'd2;

  // key status codes
  localparam logic [2:0] KS_NONE       = 3'd0;
  localparam logic [2:0] KS_PRESSED    = 3'd1;
  localparam logic [2:0] KS_AUTOREPEAT = 3'd2;
  localparam logic [2:0] KS_RELEASED   = 3'd3;
  localparam logic [2:0] KS_CHECKED    = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PERIOD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_PERIOD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AR_DELAY     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_AR_RELOAD    = 3'd6;

endpackage

### hdl/nec_ir_if.sv
interface nec_ir_req_if
  import nec_ir_pkg::*;
#(
  parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic [PERIOD_WIDTH-1:0] period;

  modport source (output valid, output req_type, output period, input ready);
  modport sink   (input valid, input req_type, input period, output ready);
endinterface

interface nec_ir_key_if
  import nec_ir_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [2:0]         key_status;
  logic [CODE_W-1:0]  key_code;
  logic               key_valid;
  logic [COUNT_W-1:0] press_repeats;
  logic               frame_done;
  logic               frame_bad;

  modport source (output valid, output key_status, output key_code, output key_valid,
                  output press_repeats, output frame_done, output frame_bad,
                  input ready);
  modport sink   (input valid, input key_status, input key_code, input key_valid,
                  input press_repeats, input frame_done, input frame_bad,
                  output ready);
endinterface

### hdl/nec_ir_pulse_decoder.sv
// NEC infrared pulse decoder
// in_req (valid/ready) carries one event: a measured edge period, a timeout
// or a consumer acknowledge. out_key (valid/ready) returns exactly one key
// status item per event, in order.
// cfg_we/cfg_index/cfg_data write the seven threshold and autorepeat
// registers; the user must make writes only while no event is in flight,
// as the block itself does not enforce this. An accepted event passes
// through one input register and one result register. Throughput: one
// event per cycle while out_key is ready; decoder state is updated in the
// result stage so each event sees the state left by the one before it.
// Reset (synchronous, rst_n low) empties both stages, clears the decoder
// state and loads the register defaults (max_period all ones, others zero).
// When out_key stalls, the result stays in its register and the input
// register still takes one more event; in_req.ready drops only once both
// stages hold an item.
module nec_ir_pulse_decoder
  import nec_ir_pkg::*;
#(
  parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  nec_ir_req_if.sink              in_req,
  nec_ir_key_if.source            out_key,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [PERIOD_WIDTH-1:0] cfg_data
);

  typedef logic [PERIOD_WIDTH-1:0] period_t;

  // configuration
  period_t           min_period_r, zero_period_r, one_period_r;
  period_t           start_period_r, max_period_r;
  logic [TICK_W-1:0] ar_delay_r, ar_reload_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r   <= '0;
      zero_period_r  <= '0;
      one_period_r   <= '0;
      start_period_r <= '0;
      max_period_r   <= '1;
      ar_delay_r     <= '0;
      ar_reload_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_PERIOD:   min_period_r   <= cfg_data;
        CFG_ZERO_PERIOD:  zero_period_r  <= cfg_data;
        CFG_ONE_PERIOD:   one_period_r   <= cfg_data;
        CFG_START_PERIOD: start_period_r <= cfg_data;
        CFG_MAX_PERIOD:   max_period_r   <= cfg_data;
        CFG_AR_DELAY:     ar_delay_r     <= cfg_data[TICK_W-1:0];
        CFG_AR_RELOAD:    ar_reload_r    <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic    in_valid_r, out_valid_r;
  logic    out_load, in_load;
  logic    [1:0] req_r;
  period_t period_r;

  assign out_load     = in_valid_r && (!out_valid_r || out_key.ready);
  assign in_req.ready = !in_valid_r || out_load;
  assign in_load      = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      in_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      req_r    <= in_req.req_type;
      period_r <= in_req.period;
    end
  end

  // decoder state
  logic [BITPOS_W-1:0]   bitpos_r, bitpos_nxt;
  logic [FRAME_BITS-1:0] shift_r, shift_nxt;
  logic [CODE_W-1:0]     code_r, code_nxt;
  logic                  held_r, held_nxt;
  logic [TICK_W-1:0]     ticks_r, ticks_nxt;
  logic [COUNT_W-1:0]    repeats_r, repeats_nxt;
  logic [2:0]            status_r, status_nxt;
  logic                  done_nxt, bad_nxt;

  period_t               t;
  logic                  active;
  logic [TICK_W-1:0]     ticks_inc;
  logic [FRAME_BITS-1:0] shifted;
  logic                  frame_ok;

  always_comb begin
    bitpos_nxt  = bitpos_r;
    shift_nxt   = shift_r;
    code_nxt    = code_r;
    held_nxt    = held_r;
    ticks_nxt   = ticks_r;
    repeats_nxt = repeats_r;
    status_nxt  = status_r;
    done_nxt    = 1'b0;
    bad_nxt     = 1'b0;
    t           = '0;
    active      = 1'b0;
    ticks_inc   = '0;
    shifted     = '0;
    frame_ok    = 1'b0;

    case (req_r)
      REQ_ACK: begin
        status_nxt = KS_CHECKED;
      end
      REQ_PERIOD: begin
        active = 1'b1;
        t      = (period_r > max_period_r) ? '0 : period_r;
      end
      REQ_TIMEOUT: begin
        active = 1'b1;
        if (held_r && (ticks_r != '0)) begin
          ticks_nxt  = '0;
          status_nxt = KS_RELEASED;
        end else begin
          code_nxt    = '0;
          held_nxt    = 1'b0;
          ticks_nxt   = '0;
          repeats_nxt = '0;
          status_nxt  = KS_NONE;
        end
      end
      default: ;
    endcase

    if (active) begin
      if ((t < min_period_r) || (t > start_period_r)) begin
        bitpos_nxt = '0;
      end else if (!bitpos_r[BITPOS_W-1]) begin
        if (t > one_period_r) begin
          // repeat pulse
          repeats_nxt = repeats_nxt + 1'b1;
          ticks_inc   = ticks_nxt + 1'b1;
          ticks_nxt   = ticks_inc;
          if (ticks_inc > ar_delay_r) begin
            status_nxt = KS_AUTOREPEAT;
            ticks_nxt  = ar_reload_r;
          end else if (status_nxt == KS_CHECKED) begin
            status_nxt = KS_NONE;
          end
        end else begin
          shifted    = {(t > zero_period_r), shift_r[FRAME_BITS-1:1]};
          shift_nxt  = shifted;
          bitpos_nxt = bitpos_r + 1'b1;
          if (bitpos_r == BITPOS_LAST) begin
            frame_ok = ((shifted[7:0] ^ shifted[15:8]) == BYTE_ONES) &&
                       ((shifted[23:16] ^ shifted[31:24]) == BYTE_ONES);
            done_nxt   = 1'b1;
            bitpos_nxt = BITPOS_WAIT;
            if (!frame_ok) begin
              bad_nxt   = 1'b1;
              shift_nxt = '0;
            end else begin
              code_nxt    = {shifted[7:0], shifted[23:16]};
              held_nxt    = 1'b1;
              ticks_nxt   = TICK_W'(1);
              repeats_nxt = '0;
              status_nxt  = KS_PRESSED;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitpos_r  <= '0;
      shift_r   <= '0;
      code_r    <= '0;
      held_r    <= 1'b0;
      ticks_r   <= '0;
      repeats_r <= '0;
      status_r  <= KS_NONE;
    end else if (out_load) begin
      bitpos_r  <= bitpos_nxt;
      shift_r   <= shift_nxt;
      code_r    <= code_nxt;
      held_r    <= held_nxt;
      ticks_r   <= ticks_nxt;
      repeats_r <= repeats_nxt;
      status_r  <= status_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_key.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  logic [2:0]         key_status_r;
  logic [CODE_W-1:0]  key_code_r;
  logic               key_valid_r;
  logic [COUNT_W-1:0] press_repeats_r;
  logic               frame_done_r, frame_bad_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      key_status_r    <= status_nxt;
      key_code_r      <= held_nxt ? code_nxt : '0;
      key_valid_r     <= held_nxt;
      press_repeats_r <= repeats_nxt;
      frame_done_r    <= done_nxt;
      frame_bad_r     <= bad_nxt;
    end
  end

  assign out_key.valid         = out_valid_r;
  assign out_key.key_status    = key_status_r;
  assign out_key.key_code      = key_code_r;
  assign out_key.key_valid     = key_valid_r;
  assign out_key.press_repeats = press_repeats_r;
  assign out_key.frame_done    = frame_done_r;
  assign out_key.frame_bad     = frame_bad_r;

endmodule
